>>> rtl/dht_pkg.sv
// shared types, constants and codes for the double hashing insert table
`timescale 1ns / 1ps
package dht_pkg;

	localparam int KEY_W     = 31;
	localparam int SLOT_W    = 7;
	localparam int CNT_W     = 8;
	localparam int STAT_W    = 2;
	localparam int TSIZE_W   = 8;
	localparam int PRIME_W   = 7;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int Q_DEPTH   = 2;

	localparam int DEF_TABLE_DEPTH = 128;

	localparam logic [TSIZE_W-1:0] RST_TABLE_SIZE  = 8'd128;
	localparam logic [PRIME_W-1:0] RST_PROBE_PRIME = 7'd7;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_PRIME = 1'b1;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_BAD_KEY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CLS_READ,
		CLS_BAD_KEY,
		CLS_INSERT
	} class_t;

	typedef struct packed {
		class_t             cls;
		logic [KEY_W-1:0]   key;
		logic [SLOT_W-1:0]  slot;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	typedef struct packed {
		logic [TSIZE_W-1:0] table_size;
		logic [PRIME_W-1:0] probe_prime;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_READ_DATA,
		ST_HASH,
		ST_STEP,
		ST_HOME_RD,
		ST_HOME_CHK,
		ST_PROBE_RD,
		ST_PROBE_CHK
	} back_state_t;

endpackage

>>> rtl/dht_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module dht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/dht_div.sv
// iterative restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module dht_div #(
	parameter int DVD_W = 31,
	parameter int DVS_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVS_W-1:0] rem
);

	localparam int CW = $clog2(DVD_W + 1);

	logic             run_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic             done_q;
	logic [DVS_W:0]   trial;

	assign trial = {rem_q, dvd_q[DVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			// partial remainder stays below the divisor
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVS_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> rtl/dht_front.sv
// command intake: classifies each beat and queues it for the back end
`timescale 1ns / 1ps
module dht_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        command,
	input  logic [dht_pkg::KEY_W-1:0]   key,
	input  logic [dht_pkg::SLOT_W-1:0]  slot,
	output logic                        busy,
	output dht_pkg::q_head_t            head,
	input  dht_pkg::back_ctl_t          ctl
);

	localparam int PW = $clog2(dht_pkg::Q_DEPTH);
	localparam int NW = $clog2(dht_pkg::Q_DEPTH + 1);

	dht_pkg::item_t  entry_q [dht_pkg::Q_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [NW-1:0]   cnt_q;
	dht_pkg::item_t  in_item;
	logic            push;
	logic            full;

	always_comb begin
		in_item.key  = key;
		in_item.slot = slot;
		priority if (command == dht_pkg::CMD_READ) begin
			in_item.cls = dht_pkg::CLS_READ;
		end else if (key == '0) begin
			in_item.cls = dht_pkg::CLS_BAD_KEY;
		end else begin
			in_item.cls = dht_pkg::CLS_INSERT;
		end
	end

	assign full = (cnt_q == NW'(dht_pkg::Q_DEPTH));
	assign busy = full | ctl.clearing;
	assign push = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(dht_pkg::Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (ctl.pop) begin
				rp_q <= (rp_q == PW'(dht_pkg::Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push & ~ctl.pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (~push & ctl.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= in_item;
		end
	end

	assign head.valid = (cnt_q != '0);
	assign head.item  = entry_q[rp_q];

endmodule

>>> rtl/dht_back.sv
// execution sequencer: table clear, reads, hashing and probe loop
`timescale 1ns / 1ps
module dht_back #(
	parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dht_pkg::cfg_t               cfg,
	input  dht_pkg::q_head_t            head,
	output dht_pkg::back_ctl_t          ctl,
	output logic                        done,
	output logic [dht_pkg::SLOT_W-1:0]  placed_slot,
	output logic [dht_pkg::KEY_W-1:0]   stored_key,
	output logic                        collided,
	output logic [dht_pkg::CNT_W-1:0]   probe_count,
	output logic [dht_pkg::STAT_W-1:0]  status
);

	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int SW  = $clog2(TABLE_DEPTH + 1);
	localparam int DVW = (SW > dht_pkg::PRIME_W) ? SW : dht_pkg::PRIME_W;

	dht_pkg::back_state_t state_q, state_d;

	logic [IW-1:0]                clr_q;
	logic [dht_pkg::KEY_W-1:0]    key_q;
	logic [dht_pkg::SLOT_W-1:0]   slot_q;
	logic                         slot_ok_q;
	logic [IW-1:0]                home_q;
	logic [IW-1:0]                idx_q;
	logic [SW-1:0]                step_q;
	logic [SW-1:0]                n_q;
	logic [dht_pkg::KEY_W-1:0]    home_key_q;

	logic                         done_q;
	logic [dht_pkg::SLOT_W-1:0]   placed_q;
	logic [dht_pkg::KEY_W-1:0]    stored_q;
	logic                         coll_q;
	logic [dht_pkg::CNT_W-1:0]    probes_q;
	dht_pkg::status_t             status_q;

	logic [SW-1:0]                size;
	logic [dht_pkg::PRIME_W-1:0]  prime;
	int unsigned                  ts_i;

	logic                         ram_we;
	logic [IW-1:0]                ram_waddr;
	logic [dht_pkg::KEY_W-1:0]    ram_wdata;
	logic [IW-1:0]                ram_raddr;
	logic [dht_pkg::KEY_W-1:0]    ram_rdata;

	logic                         diva_start, divb_start;
	logic                         diva_done, divb_done;
	logic [DVW-1:0]               diva_rem, divb_rem;
	logic [dht_pkg::KEY_W-1:0]    divb_dvd;
	logic [DVW-1:0]               divb_dvs;
	logic [dht_pkg::PRIME_W-1:0]  step_raw;

	logic [SW:0]                  sum;
	logic [IW-1:0]                idx_nxt;
	logic                         head_ins;
	logic                         head_rd;
	logic                         head_bad;

	// clamp the configured table size and prime
	always_comb begin
		ts_i = 32'(cfg.table_size);
		if (ts_i < 2) begin
			ts_i = 2;
		end
		if (ts_i > TABLE_DEPTH) begin
			ts_i = TABLE_DEPTH;
		end
		size  = SW'(ts_i);
		prime = (cfg.probe_prime == '0) ? dht_pkg::PRIME_W'(1) : cfg.probe_prime;
	end

	assign step_raw = prime - dht_pkg::PRIME_W'(divb_rem);

	// idx and step are both below size, so one subtract wraps
	assign sum     = {1'b0, SW'(idx_q)} + {1'b0, step_q};
	assign idx_nxt = (sum >= {1'b0, size}) ? IW'(sum - {1'b0, size}) : IW'(sum);

	assign head_ins = head.valid && (head.item.cls == dht_pkg::CLS_INSERT);
	assign head_rd  = head.valid && (head.item.cls == dht_pkg::CLS_READ);
	assign head_bad = head.valid && (head.item.cls == dht_pkg::CLS_BAD_KEY);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dht_pkg::ST_CLEAR: begin
				if (clr_q == IW'(TABLE_DEPTH - 1)) begin
					state_d = dht_pkg::ST_IDLE;
				end
			end
			dht_pkg::ST_IDLE: begin
				if (head_rd) begin
					state_d = dht_pkg::ST_READ;
				end else if (head_ins) begin
					state_d = dht_pkg::ST_HASH;
				end
			end
			dht_pkg::ST_READ:      state_d = dht_pkg::ST_READ_DATA;
			dht_pkg::ST_READ_DATA: state_d = dht_pkg::ST_IDLE;
			dht_pkg::ST_HASH: begin
				if (diva_done) begin
					state_d = dht_pkg::ST_STEP;
				end
			end
			dht_pkg::ST_STEP: begin
				if (divb_done) begin
					state_d = dht_pkg::ST_HOME_RD;
				end
			end
			dht_pkg::ST_HOME_RD:  state_d = dht_pkg::ST_HOME_CHK;
			dht_pkg::ST_HOME_CHK: begin
				state_d = (ram_rdata == '0) ? dht_pkg::ST_IDLE : dht_pkg::ST_PROBE_RD;
			end
			dht_pkg::ST_PROBE_RD: state_d = dht_pkg::ST_PROBE_CHK;
			dht_pkg::ST_PROBE_CHK: begin
				if (ram_rdata == '0 || n_q == size) begin
					state_d = dht_pkg::ST_IDLE;
				end else begin
					state_d = dht_pkg::ST_PROBE_RD;
				end
			end
			default: state_d = dht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.pop      = 1'b0;
		ctl.clearing = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = idx_q;
		ram_wdata    = key_q;
		ram_raddr    = idx_q;
		diva_start   = 1'b0;
		divb_start   = 1'b0;
		divb_dvd     = head.item.key;
		divb_dvs     = DVW'(prime);
		unique case (state_q)
			dht_pkg::ST_CLEAR: begin
				ctl.clearing = 1'b1;
				ram_we       = 1'b1;
				ram_waddr    = clr_q;
				ram_wdata    = '0;
			end
			dht_pkg::ST_IDLE: begin
				ctl.pop    = head.valid;
				diva_start = head_ins;
				divb_start = head_ins;
			end
			dht_pkg::ST_READ: begin
				ram_raddr = IW'(slot_q);
			end
			dht_pkg::ST_HASH: begin
				// second pass of the step unit reduces the step
				divb_start = diva_done;
				divb_dvd   = dht_pkg::KEY_W'(step_raw);
				divb_dvs   = DVW'(size);
			end
			dht_pkg::ST_HOME_RD: begin
				ram_raddr = home_q;
			end
			dht_pkg::ST_HOME_CHK: begin
				ram_we    = (ram_rdata == '0);
				ram_waddr = home_q;
			end
			dht_pkg::ST_PROBE_RD: begin
				ram_raddr = idx_nxt;
			end
			dht_pkg::ST_PROBE_CHK: begin
				ram_we = (ram_rdata == '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dht_pkg::ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dht_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			done_q <= ((state_q == dht_pkg::ST_IDLE) && head_bad)
				|| (state_q == dht_pkg::ST_READ_DATA)
				|| ((state_q == dht_pkg::ST_HOME_CHK) && (ram_rdata == '0))
				|| ((state_q == dht_pkg::ST_PROBE_CHK)
					&& (ram_rdata == '0 || n_q == size));
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			dht_pkg::ST_IDLE: begin
				key_q     <= head.item.key;
				slot_q    <= head.item.slot;
				slot_ok_q <= (32'(head.item.slot) < TABLE_DEPTH);
				placed_q  <= '0;
				stored_q  <= '0;
				coll_q    <= 1'b0;
				probes_q  <= '0;
				status_q  <= dht_pkg::STAT_BAD_KEY;
			end
			dht_pkg::ST_READ_DATA: begin
				placed_q <= slot_q;
				stored_q <= slot_ok_q ? ram_rdata : '0;
				coll_q   <= 1'b0;
				probes_q <= '0;
				status_q <= dht_pkg::STAT_OK;
			end
			dht_pkg::ST_HASH: begin
				if (diva_done) begin
					home_q <= IW'(diva_rem);
				end
			end
			dht_pkg::ST_STEP: begin
				if (divb_done) begin
					step_q <= SW'(divb_rem);
				end
			end
			dht_pkg::ST_HOME_CHK: begin
				home_key_q <= ram_rdata;
				idx_q      <= home_q;
				n_q        <= SW'(1);
				placed_q   <= dht_pkg::SLOT_W'(home_q);
				stored_q   <= key_q;
				coll_q     <= 1'b0;
				probes_q   <= '0;
				status_q   <= dht_pkg::STAT_OK;
			end
			dht_pkg::ST_PROBE_RD: begin
				idx_q <= idx_nxt;
			end
			dht_pkg::ST_PROBE_CHK: begin
				n_q    <= n_q + 1'b1;
				coll_q <= 1'b1;
				if (ram_rdata == '0) begin
					placed_q <= dht_pkg::SLOT_W'(idx_q);
					stored_q <= key_q;
					probes_q <= (32'(n_q) > 255) ? 8'd255 : dht_pkg::CNT_W'(n_q);
					status_q <= dht_pkg::STAT_OK;
				end else begin
					placed_q <= dht_pkg::SLOT_W'(home_q);
					stored_q <= home_key_q;
					probes_q <= (32'(size) > 255) ? 8'd255 : dht_pkg::CNT_W'(size);
					status_q <= dht_pkg::STAT_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	dht_ram #(
		.WIDTH(dht_pkg::KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dht_div #(
		.DVD_W(dht_pkg::KEY_W),
		.DVS_W(DVW)
	) u_div_home (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (diva_start),
		.dividend (head.item.key),
		.divisor  (DVW'(size)),
		.done     (diva_done),
		.rem      (diva_rem)
	);

	dht_div #(
		.DVD_W(dht_pkg::KEY_W),
		.DVS_W(DVW)
	) u_div_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (divb_start),
		.dividend (divb_dvd),
		.divisor  (divb_dvs),
		.done     (divb_done),
		.rem      (divb_rem)
	);

	assign done        = done_q;
	assign placed_slot = placed_q;
	assign stored_key  = stored_q;
	assign collided    = coll_q;
	assign probe_count = probes_q;
	assign status      = status_q;

endmodule

>>> rtl/double_hash_table_insert.sv
// top level of the double hashing insert table
//
//   channel   signals                                   handshake
//   command   start, command, key, slot                 beat taken when start & !busy
//   result    done, placed_slot, stored_key, collided,  one-cycle strobe on done
//             probe_count, status
//   config    cfg_we, cfg_index, cfg_data               write when cfg_we is high
//
// from the accepting edge to the result edge with the sequencer idle: a read passes
// the read states, a zero key only the idle state, an insert two remainder passes and
// a home slot read and check, then another read and check per probe of the table ram.
// after reset the table is cleared one slot a cycle, every slot in turn, with busy high.
// a two-beat queue lets commands be taken while the sequencer works; busy
// rises when it is full. results cannot be held off by the receiver.
`timescale 1ns / 1ps
module double_hash_table_insert #(
	parameter int TABLE_DEPTH = dht_pkg::DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [dht_pkg::KEY_W-1:0]     key,
	input  logic [dht_pkg::SLOT_W-1:0]    slot,
	output logic                          done,
	output logic [dht_pkg::SLOT_W-1:0]    placed_slot,
	output logic [dht_pkg::KEY_W-1:0]     stored_key,
	output logic                          collided,
	output logic [dht_pkg::CNT_W-1:0]     probe_count,
	output logic [dht_pkg::STAT_W-1:0]    status,
	input  logic                          cfg_we,
	input  logic [dht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dht_pkg::CFG_W-1:0]     cfg_data
);

	dht_pkg::cfg_t      cfg_q;
	dht_pkg::q_head_t   head;
	dht_pkg::back_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.table_size  <= dht_pkg::RST_TABLE_SIZE;
			cfg_q.probe_prime <= dht_pkg::RST_PROBE_PRIME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dht_pkg::REG_TABLE_SIZE:  cfg_q.table_size <= cfg_data;
				dht_pkg::REG_PROBE_PRIME: begin
					cfg_q.probe_prime <= cfg_data[dht_pkg::PRIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	dht_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.key     (key),
		.slot    (slot),
		.busy    (busy),
		.head    (head),
		.ctl     (ctl)
	);

	dht_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.ctl         (ctl),
		.done        (done),
		.placed_slot (placed_slot),
		.stored_key  (stored_key),
		.collided    (collided),
		.probe_count (probe_count),
		.status      (status)
	);

endmodule

>>> tb/double_hash_table_insert_chk.sv
// checker for the double hashing insert table: predicts results and compares them
`timescale 1ns / 1ps
module double_hash_table_insert_chk
	import dht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 command,
	input  logic [KEY_W-1:0]     key,
	input  logic [SLOT_W-1:0]    slot,
	input  logic                 done,
	input  logic [SLOT_W-1:0]    placed_slot,
	input  logic [KEY_W-1:0]     stored_key,
	input  logic                 collided,
	input  logic [CNT_W-1:0]     probe_count,
	input  logic [STAT_W-1:0]    status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   n_full,
	output int                   n_coll
);

	localparam int DEPTH = DEF_TABLE_DEPTH;

	typedef struct {
		logic [SLOT_W-1:0] placed;
		logic [KEY_W-1:0]  held;
		logic              coll;
		logic [CNT_W-1:0]  probes;
		status_t           stat;
	} outcome_t;

	logic [KEY_W-1:0]   shadow_table [DEPTH];
	logic [TSIZE_W-1:0] size_reg;
	logic [PRIME_W-1:0] prime_reg;
	outcome_t           outcome_q[$];

	function automatic outcome_t place_key(logic cmd, logic [KEY_W-1:0] k,
			logic [SLOT_W-1:0] s);
		outcome_t r;
		int sz, p, home, stride, idx;
		r = '{placed: '0, held: '0, coll: 1'b0, probes: '0, stat: STAT_OK};
		if (cmd == CMD_READ) begin
			r.placed = s;
			r.held = (int'(s) < DEPTH) ? shadow_table[s] : '0;
			return r;
		end
		if (k == 0) begin
			r.stat = STAT_BAD_KEY;
			return r;
		end
		sz = int'(size_reg);
		if (sz < 2) sz = 2;
		if (sz > DEPTH) sz = DEPTH;
		p = (prime_reg == 0) ? 1 : int'(prime_reg);
		home = int'(k % sz);
		if (shadow_table[home] == 0) begin
			shadow_table[home] = k;
			r.placed = SLOT_W'(home);
			r.held = k;
			return r;
		end
		stride = (p - int'(k % p)) % sz;
		idx = home;
		r.coll = 1'b1;
		for (int n = 1; n <= sz; n++) begin
			idx = (idx + stride) % sz;
			if (shadow_table[idx] == 0) begin
				shadow_table[idx] = k;
				r.placed = SLOT_W'(idx);
				r.held = k;
				r.probes = CNT_W'(n);
				n_coll++;
				return r;
			end
		end
		r.placed = SLOT_W'(home);
		r.held = shadow_table[home];
		r.probes = CNT_W'((sz > 255) ? 255 : sz);
		r.stat = STAT_FULL;
		n_full++;
		return r;
	endfunction

	assign pending = outcome_q.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			foreach (shadow_table[i]) shadow_table[i] = '0;
			size_reg = RST_TABLE_SIZE;
			prime_reg = RST_PROBE_PRIME;
			outcome_q.delete();
			fail_count = 0;
			n_full = 0;
			n_coll = 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result beat with nothing expected");
					fail_count++;
				end else begin
					e = outcome_q.pop_front();
					if (placed_slot !== e.placed) begin
						$error("placed_slot exp %0d got %0d", e.placed, placed_slot);
						fail_count++;
					end
					if (stored_key !== e.held) begin
						$error("stored_key exp %0d got %0d", e.held, stored_key);
						fail_count++;
					end
					if (collided !== e.coll) begin
						$error("collided exp %0d got %0d", e.coll, collided);
						fail_count++;
					end
					if (probe_count !== e.probes) begin
						$error("probe_count exp %0d got %0d", e.probes, probe_count);
						fail_count++;
					end
					if (status !== e.stat) begin
						$error("status exp %0d got %0d", e.stat, status);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(place_key(command, key, slot));
			if (cfg_we) begin
				if (cfg_index == REG_TABLE_SIZE) size_reg = cfg_data;
				else prime_reg = cfg_data[PRIME_W-1:0];
			end
		end
	end

endmodule

>>> tb/double_hash_table_insert_tb.sv
// stimulus and verdict for the double hashing insert table
`timescale 1ns / 1ps
module double_hash_table_insert_tb;
	import dht_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 command;
	logic [KEY_W-1:0]     key;
	logic [SLOT_W-1:0]    slot;
	logic                 done;
	logic [SLOT_W-1:0]    placed_slot;
	logic [KEY_W-1:0]     stored_key;
	logic                 collided;
	logic [CNT_W-1:0]     probe_count;
	logic [STAT_W-1:0]    status;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count;
	int                   pending;
	int                   n_full;
	int                   n_coll;
	int                   idle_cycles;
	int                   beats;
	bit                   idle_on;

	double_hash_table_insert i_dut (.*);

	double_hash_table_insert_chk i_chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCH_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// start stays high after the beat so the next one can follow at once
	task automatic issue(logic cmd, logic [KEY_W-1:0] k, logic [SLOT_W-1:0] s);
		while (idle_on && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		key <= k;
		slot <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		beats++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly small keys so homes collide, a few full-width ones and occasional zero keys
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0: return '0;
			1, 2: return KEY_W'($urandom());
			default: return KEY_W'($urandom_range(400, 1));
		endcase
	endfunction

	initial begin
		int sizes[6] = '{2, 128, 5, 17, 64, 3};
		int primes[6] = '{0, 127, 1, 13, 7, 2};
		idle_on = 1'b0;
		beats = 0;
		idle_cycles = 0;
		start = 1'b0;
		command = CMD_INSERT;
		key = '0;
		slot = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TABLE_SIZE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default config, extremes, bad key, collisions, reads
		issue(CMD_INSERT, '0, '0);
		issue(CMD_INSERT, {KEY_W{1'b1}}, {SLOT_W{1'b1}});
		issue(CMD_INSERT, 31'd1, '0);
		issue(CMD_INSERT, 31'd129, '0);
		issue(CMD_INSERT, 31'd257, '0);
		issue(CMD_INSERT, 31'd1, '0);
		issue(CMD_READ, {KEY_W{1'b1}}, 7'd1);
		issue(CMD_READ, '0, {SLOT_W{1'b1}});
		issue(CMD_READ, '0, 7'd0);
		drain();
		// table size below range, zero prime: fills and reports full
		set_reg(REG_TABLE_SIZE, 8'd0);
		set_reg(REG_PROBE_PRIME, 8'd0);
		issue(CMD_INSERT, 31'd2, '0);
		issue(CMD_INSERT, 31'd4, '0);
		issue(CMD_INSERT, 31'd6, '0);
		issue(CMD_READ, '0, 7'd100);
		drain();
		// oversized table size clamps to depth
		set_reg(REG_TABLE_SIZE, 8'd255);
		set_reg(REG_PROBE_PRIME, 8'd127);
		issue(CMD_INSERT, 31'd300, '0);
		issue(CMD_INSERT, 31'd428, '0);
		drain();

		// random phases over several configs; a no-idle stretch in the first
		for (int ph = 0; ph < 6; ph++) begin
			set_reg(REG_TABLE_SIZE, CFG_W'(sizes[ph]));
			set_reg(REG_PROBE_PRIME, CFG_W'(primes[ph]));
			idle_on = (ph != 0);
			for (int i = 0; i < 115; i++) begin
				if ($urandom_range(3) == 0)
					issue(CMD_READ, KEY_W'($urandom()), SLOT_W'($urandom()));
				else
					issue(CMD_INSERT, pick_key(), SLOT_W'($urandom()));
			end
			drain();
		end

		$display("summary: %0d command beats, %0d probed inserts, %0d full reports",
			beats, n_coll, n_full);
		$display("configs covered sizes 0..255 and primes 0..127 with reads and bad keys");
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
